FILE: rtl/core/pas_pkg.sv
// Shared widths and constants for the projectile aim solver core.
package pas_pkg;

    // Port field widths
    localparam int SPEED_W = 31;
    localparam int POS_W   = 32;
    localparam int GRAV_W  = 31;
    localparam int TIME_W  = 31;
    localparam int VX_W    = 32;
    localparam int VY_W    = 31;

    // Gravity register value after reset (9.8 in Q16.16)
    localparam logic [GRAV_W-1:0] GRAV_RESET = 31'd642253;

    // Internal datapath widths
    localparam int PM_W  = 63;   // positive -B term
    localparam int V2_W  = 62;   // v squared
    localparam int CQ_W  = 64;   // x^2 + y^2
    localparam int G2_W  = 62;   // g squared
    localparam int WD_W  = 128;  // wide products
    localparam int D4_W  = 126;  // discriminant
    localparam int S_W   = 63;   // root of discriminant
    localparam int NUM_W = 64;   // root numerator
    localparam int VX2_W = 63;   // vx squared
    localparam int RAD_W = 62;   // vertical radicand

    // Saturation limits
    localparam logic [TIME_W-1:0] TIME_MAX = 31'h7FFF_FFFF;
    localparam logic [VX_W-1:0]   VX_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VX_W-1:0]   VX_NEG_MAX = 32'h8000_0000;

endpackage

FILE: rtl/core/projectile_aim_solver_core.sv
// Pipelined fixed-point launch solver for a projectile at fixed speed.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  request   | start / busy              | i_launch_speed, i_target_x, i_target_y
//  result    | o_valid (one-cycle strobe)| o_reachable, o_flight_time, o_velocity_x,
//            |                           | o_velocity_y
//  gravity   | i_cfg_valid / o_cfg_ready | i_cfg_gravity
//
// One request is taken every cycle; busy is never raised.
// Each result passes through the bit-per-stage root and divide chains (three square roots,
// two dividers), whose total length grows with FRAC_BITS (Q16.16 by default).
// Reset clears the stage valid bits and loads gravity with its default value.
// The result side has no backpressure, so the pipeline never stalls.
module projectile_aim_solver_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [pas_pkg::SPEED_W-1:0]   i_launch_speed,
    input  logic signed [pas_pkg::POS_W-1:0]     i_target_x,
    input  logic signed [pas_pkg::POS_W-1:0]     i_target_y,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [pas_pkg::GRAV_W-1:0]    i_cfg_gravity,
    output logic                                 o_valid,
    output logic                                 o_reachable,
    output logic        [pas_pkg::TIME_W-1:0]    o_flight_time,
    output logic signed [pas_pkg::VX_W-1:0]      o_velocity_x,
    output logic        [pas_pkg::VY_W-1:0]      o_velocity_y
);

    localparam int SH  = 2 * FRAC_BITS + 1;            // numerator scale shift
    localparam int NW  = pas_pkg::NUM_W + SH;          // T^2 dividend width
    localparam int TW  = (NW + 1) / 2;                 // flight time width
    localparam int XW  = pas_pkg::POS_W + FRAC_BITS;   // scaled |x| width
    localparam int S1N = pas_pkg::S_W;                 // discriminant root steps
    localparam int S3N = pas_pkg::VY_W;                // vertical root steps
    localparam int LAT = 108 + NW + TW + XW;           // start to strobe, sampled

    // Sideband carried alongside each item
    typedef struct packed {
        logic                               reach;
        logic                               tz;
        logic        [pas_pkg::PM_W-1:0]    pm;
        logic        [pas_pkg::V2_W-1:0]    v2;
        logic signed [pas_pkg::POS_W-1:0]   x;
        logic        [TW-1:0]               t;
        logic signed [pas_pkg::VX_W-1:0]    vx;
    } t_side;

    // Gravity register and its square
    logic [pas_pkg::GRAV_W-1:0] r_gravity;
    logic [pas_pkg::G2_W-1:0]   r_g2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= pas_pkg::GRAV_RESET;
        end else if (i_cfg_valid) begin
            r_gravity <= i_cfg_gravity;
        end
        r_g2 <= pas_pkg::G2_W'(r_gravity) * pas_pkg::G2_W'(r_gravity);
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Stage A: capture request
    logic                               r_a_vld;
    logic        [pas_pkg::SPEED_W-1:0] r_a_v;
    logic signed [pas_pkg::POS_W-1:0]   r_a_x;
    logic signed [pas_pkg::POS_W-1:0]   r_a_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_v <= i_launch_speed;
        r_a_x <= i_target_x;
        r_a_y <= i_target_y;
    end

    // Stage B: squares and y*g
    logic                               r_b_vld;
    logic                               r_b_gz;
    logic        [pas_pkg::V2_W-1:0]    r_b_v2;
    logic signed [63:0]                 r_b_yg;
    logic        [63:0]                 r_b_xx;
    logic        [63:0]                 r_b_yy;
    logic signed [pas_pkg::POS_W-1:0]   r_b_x;
    logic        [31:0]                 ax;
    logic        [31:0]                 ay;
    logic signed [63:0]                 n_b_yg;

    always_comb begin
        ax     = r_a_x[31] ? (~r_a_x + 32'd1) : r_a_x;
        ay     = r_a_y[31] ? (~r_a_y + 32'd1) : r_a_y;
        n_b_yg = 64'(r_a_y) * 64'($signed({1'b0, r_gravity}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_gz <= (r_gravity == '0);
        r_b_v2 <= pas_pkg::V2_W'(r_a_v) * pas_pkg::V2_W'(r_a_v);
        r_b_yg <= n_b_yg;
        r_b_xx <= 64'(ax) * 64'(ax);
        r_b_yy <= 64'(ay) * 64'(ay);
        r_b_x  <= r_a_x;
    end

    // Stage C: P = v^2 + y*g, C = x^2 + y^2
    logic                           r_c_vld;
    t_side                          r_c_side;
    logic [pas_pkg::CQ_W-1:0]       r_c_cq;
    logic signed [63:0]             p_sum;
    t_side                          n_c_side;

    always_comb begin
        p_sum          = $signed({2'b00, r_b_v2}) + r_b_yg;
        n_c_side       = '0;
        n_c_side.reach = !r_b_gz && !p_sum[63] && (p_sum != 64'sd0);
        n_c_side.pm    = p_sum[pas_pkg::PM_W-1:0];
        n_c_side.v2    = r_b_v2;
        n_c_side.x     = r_b_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_side <= n_c_side;
        r_c_cq   <= r_b_xx + r_b_yy;
    end

    // Stage D: 32-bit partial products of P*P and G2*C
    logic         r_d_vld;
    t_side        r_d_side;
    logic [63:0]  r_d_a00, r_d_a01, r_d_a11;
    logic [63:0]  r_d_b00, r_d_b01, r_d_b10, r_d_b11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_side <= r_c_side;
        r_d_a00  <= 64'(r_c_side.pm[31:0])  * 64'(r_c_side.pm[31:0]);
        r_d_a01  <= 64'(r_c_side.pm[31:0])  * 64'(r_c_side.pm[62:32]);
        r_d_a11  <= 64'(r_c_side.pm[62:32]) * 64'(r_c_side.pm[62:32]);
        r_d_b00  <= 64'(r_g2[31:0])  * 64'(r_c_cq[31:0]);
        r_d_b01  <= 64'(r_g2[31:0])  * 64'(r_c_cq[63:32]);
        r_d_b10  <= 64'(r_g2[61:32]) * 64'(r_c_cq[31:0]);
        r_d_b11  <= 64'(r_g2[61:32]) * 64'(r_c_cq[63:32]);
    end

    // Stage E1: middle term of G2*C
    logic         r_e1_vld;
    t_side        r_e1_side;
    logic [63:0]  r_e1_a00, r_e1_a01, r_e1_a11, r_e1_b00, r_e1_b11;
    logic [64:0]  r_e1_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= r_d_vld;
        end
        r_e1_side <= r_d_side;
        r_e1_a00  <= r_d_a00;
        r_e1_a01  <= r_d_a01;
        r_e1_a11  <= r_d_a11;
        r_e1_b00  <= r_d_b00;
        r_e1_b11  <= r_d_b11;
        r_e1_mid  <= 65'(r_d_b01) + 65'(r_d_b10);
    end

    // Stage E2: full 128-bit products
    logic                       r_e2_vld;
    t_side                      r_e2_side;
    logic [pas_pkg::WD_W-1:0]   r_e2_p2;
    logic [pas_pkg::WD_W-1:0]   r_e2_gc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else begin
            r_e2_vld <= r_e1_vld;
        end
        r_e2_side <= r_e1_side;
        r_e2_p2   <= pas_pkg::WD_W'(r_e1_a00) + (pas_pkg::WD_W'(r_e1_a01) << 33)
                   + (pas_pkg::WD_W'(r_e1_a11) << 64);
        r_e2_gc   <= pas_pkg::WD_W'(r_e1_b00) + (pas_pkg::WD_W'(r_e1_mid) << 32)
                   + (pas_pkg::WD_W'(r_e1_b11) << 64);
    end

    // Discriminant root: one result bit per stage
    logic                       r_sq1_vld  [0:S1N];
    t_side                      r_sq1_side [0:S1N];
    logic [pas_pkg::D4_W-1:0]   r_sq1_rem  [0:S1N];
    logic [pas_pkg::S_W-1:0]    r_sq1_root [0:S1N];
    logic [pas_pkg::WD_W:0]     d4_diff;
    t_side                      n_sq1_side;

    // Stage E3: D = P^2 - G2*C, reject when negative
    always_comb begin
        d4_diff          = {1'b0, r_e2_p2} - {1'b0, r_e2_gc};
        n_sq1_side       = r_e2_side;
        n_sq1_side.reach = r_e2_side.reach && !d4_diff[pas_pkg::WD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq1_vld[0] <= 1'b0;
        end else begin
            r_sq1_vld[0] <= r_e2_vld;
        end
        r_sq1_side[0] <= n_sq1_side;
        r_sq1_rem[0]  <= d4_diff[pas_pkg::D4_W-1:0];
        r_sq1_root[0] <= '0;
    end

    for (genvar k = 0; k < S1N; k++) begin : g_sq1
        localparam int B = S1N - 1 - k;
        logic [pas_pkg::D4_W-1:0] trial;
        logic                     ge;

        always_comb begin
            trial = (pas_pkg::D4_W'(r_sq1_root[k]) << (B + 1))
                  | (pas_pkg::D4_W'(1) << (2 * B));
            ge    = (r_sq1_rem[k] >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq1_vld[k+1] <= 1'b0;
            end else begin
                r_sq1_vld[k+1] <= r_sq1_vld[k];
            end
            r_sq1_side[k+1] <= r_sq1_side[k];
            r_sq1_rem[k+1]  <= ge ? (r_sq1_rem[k] - trial) : r_sq1_rem[k];
            r_sq1_root[k+1] <= ge ? (r_sq1_root[k] | (pas_pkg::S_W'(1) << B))
                                  : r_sq1_root[k];
        end
    end

    // T^2 divider: quotient of numerator * 2^(2F+1) by G2, one bit per stage
    logic                       r_dv1_vld  [0:NW];
    t_side                      r_dv1_side [0:NW];
    logic [NW-1:0]              r_dv1_num  [0:NW];
    logic [pas_pkg::G2_W-1:0]   r_dv1_rem  [0:NW];
    logic [NW-1:0]              r_dv1_quo  [0:NW];
    logic [pas_pkg::NUM_W-1:0]  root_num;

    // Numerator: smaller root first, larger one when P - s is not positive
    always_comb begin
        if (r_sq1_side[S1N].pm > r_sq1_root[S1N]) begin
            root_num = {1'b0, r_sq1_side[S1N].pm} - {1'b0, r_sq1_root[S1N]};
        end else begin
            root_num = {1'b0, r_sq1_side[S1N].pm} + {1'b0, r_sq1_root[S1N]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv1_vld[0] <= 1'b0;
        end else begin
            r_dv1_vld[0] <= r_sq1_vld[S1N];
        end
        r_dv1_side[0] <= r_sq1_side[S1N];
        r_dv1_num[0]  <= {root_num, SH'(0)};
        r_dv1_rem[0]  <= '0;
        r_dv1_quo[0]  <= '0;
    end

    for (genvar i = 0; i < NW; i++) begin : g_dv1
        localparam int J = NW - 1 - i;
        logic [pas_pkg::G2_W:0] shifted;
        logic [pas_pkg::G2_W:0] diff;
        logic                   ge;

        always_comb begin
            shifted = {r_dv1_rem[i], r_dv1_num[i][J]};
            diff    = shifted - {1'b0, r_g2};
            ge      = (shifted >= {1'b0, r_g2});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv1_vld[i+1] <= 1'b0;
            end else begin
                r_dv1_vld[i+1] <= r_dv1_vld[i];
            end
            r_dv1_side[i+1] <= r_dv1_side[i];
            r_dv1_num[i+1]  <= r_dv1_num[i];
            r_dv1_rem[i+1]  <= ge ? diff[pas_pkg::G2_W-1:0] : shifted[pas_pkg::G2_W-1:0];
            r_dv1_quo[i+1]  <= {r_dv1_quo[i][NW-2:0], ge};
        end
    end

    // Flight time root
    logic           r_sq2_vld  [0:TW];
    t_side          r_sq2_side [0:TW];
    logic [NW-1:0]  r_sq2_rem  [0:TW];
    logic [TW-1:0]  r_sq2_root [0:TW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq2_vld[0] <= 1'b0;
        end else begin
            r_sq2_vld[0] <= r_dv1_vld[NW];
        end
        r_sq2_side[0] <= r_dv1_side[NW];
        r_sq2_rem[0]  <= r_dv1_quo[NW];
        r_sq2_root[0] <= '0;
    end

    for (genvar k = 0; k < TW; k++) begin : g_sq2
        localparam int B = TW - 1 - k;
        logic [NW-1:0] trial;
        logic          ge;

        always_comb begin
            trial = (NW'(r_sq2_root[k]) << (B + 1)) | (NW'(1) << (2 * B));
            ge    = (r_sq2_rem[k] >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq2_vld[k+1] <= 1'b0;
            end else begin
                r_sq2_vld[k+1] <= r_sq2_vld[k];
            end
            r_sq2_side[k+1] <= r_sq2_side[k];
            r_sq2_rem[k+1]  <= ge ? (r_sq2_rem[k] - trial) : r_sq2_rem[k];
            r_sq2_root[k+1] <= ge ? (r_sq2_root[k] | (TW'(1) << B)) : r_sq2_root[k];
        end
    end

    // Horizontal divider: |x| * 2^F over flight time
    logic           r_dv2_vld  [0:XW];
    t_side          r_dv2_side [0:XW];
    logic [XW-1:0]  r_dv2_num  [0:XW];
    logic [TW-1:0]  r_dv2_rem  [0:XW];
    logic [XW-1:0]  r_dv2_quo  [0:XW];
    logic [31:0]    ax_t;
    t_side          n_dv2_side;

    always_comb begin
        ax_t          = r_sq2_side[TW].x[31] ? (~r_sq2_side[TW].x + 32'd1)
                                             : r_sq2_side[TW].x;
        n_dv2_side    = r_sq2_side[TW];
        n_dv2_side.t  = r_sq2_root[TW];
        n_dv2_side.tz = (r_sq2_root[TW] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv2_vld[0] <= 1'b0;
        end else begin
            r_dv2_vld[0] <= r_sq2_vld[TW];
        end
        r_dv2_side[0] <= n_dv2_side;
        r_dv2_num[0]  <= {ax_t, FRAC_BITS'(0)};
        r_dv2_rem[0]  <= '0;
        r_dv2_quo[0]  <= '0;
    end

    for (genvar i = 0; i < XW; i++) begin : g_dv2
        localparam int J = XW - 1 - i;
        logic [TW:0] shifted;
        logic [TW:0] diff;
        logic        ge;

        always_comb begin
            shifted = {r_dv2_rem[i], r_dv2_num[i][J]};
            diff    = shifted - {1'b0, r_dv2_side[i].t};
            ge      = (shifted >= {1'b0, r_dv2_side[i].t});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv2_vld[i+1] <= 1'b0;
            end else begin
                r_dv2_vld[i+1] <= r_dv2_vld[i];
            end
            r_dv2_side[i+1] <= r_dv2_side[i];
            r_dv2_num[i+1]  <= r_dv2_num[i];
            r_dv2_rem[i+1]  <= ge ? diff[TW-1:0] : shifted[TW-1:0];
            r_dv2_quo[i+1]  <= {r_dv2_quo[i][XW-2:0], ge};
        end
    end

    // Signed, saturated horizontal velocity; zero time saturates by the sign of x, or gives zero when x is zero
    logic         r_vx_vld;
    t_side        r_vx_side;
    logic         q_sat;
    logic [31:0]  q_low;
    logic         x_zero;
    t_side        n_vx_side;

    always_comb begin
        n_vx_side = r_dv2_side[XW];
        x_zero    = (r_dv2_side[XW].x == '0);
        q_low     = r_dv2_quo[XW][31:0];
        q_sat     = r_dv2_side[XW].tz ? !x_zero : (|r_dv2_quo[XW][XW-1:31]);
        if (r_dv2_side[XW].tz && x_zero) begin
            n_vx_side.vx = '0;
        end else if (r_dv2_side[XW].x[31]) begin
            n_vx_side.vx = q_sat ? pas_pkg::VX_NEG_MAX : (~q_low + 32'd1);
        end else begin
            n_vx_side.vx = q_sat ? pas_pkg::VX_POS_MAX : q_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx_vld <= 1'b0;
        end else begin
            r_vx_vld <= r_dv2_vld[XW];
        end
        r_vx_side <= n_vx_side;
    end

    // vx squared
    logic                       r_q_vld;
    t_side                      r_q_side;
    logic [pas_pkg::VX2_W-1:0]  r_q_vx2;
    logic [31:0]                vxm;

    always_comb begin
        vxm = r_vx_side.vx[31] ? (~r_vx_side.vx + 32'd1) : r_vx_side.vx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_vx_vld;
        end
        r_q_side <= r_vx_side;
        r_q_vx2  <= pas_pkg::VX2_W'(vxm) * pas_pkg::VX2_W'(vxm);
    end

    // Vertical radicand, clamped at zero, then its root
    logic                       r_sq3_vld  [0:S3N];
    t_side                      r_sq3_side [0:S3N];
    logic [pas_pkg::RAD_W-1:0]  r_sq3_rem  [0:S3N];
    logic [pas_pkg::VY_W-1:0]   r_sq3_root [0:S3N];
    logic [pas_pkg::VX2_W-1:0]  rad_diff;

    always_comb begin
        rad_diff = pas_pkg::VX2_W'(r_q_side.v2) - r_q_vx2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq3_vld[0] <= 1'b0;
        end else begin
            r_sq3_vld[0] <= r_q_vld;
        end
        r_sq3_side[0] <= r_q_side;
        r_sq3_rem[0]  <= (pas_pkg::VX2_W'(r_q_side.v2) > r_q_vx2)
                       ? rad_diff[pas_pkg::RAD_W-1:0] : '0;
        r_sq3_root[0] <= '0;
    end

    for (genvar k = 0; k < S3N; k++) begin : g_sq3
        localparam int B = S3N - 1 - k;
        logic [pas_pkg::RAD_W-1:0] trial;
        logic                      ge;

        always_comb begin
            trial = (pas_pkg::RAD_W'(r_sq3_root[k]) << (B + 1))
                  | (pas_pkg::RAD_W'(1) << (2 * B));
            ge    = (r_sq3_rem[k] >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq3_vld[k+1] <= 1'b0;
            end else begin
                r_sq3_vld[k+1] <= r_sq3_vld[k];
            end
            r_sq3_side[k+1] <= r_sq3_side[k];
            r_sq3_rem[k+1]  <= ge ? (r_sq3_rem[k] - trial) : r_sq3_rem[k];
            r_sq3_root[k+1] <= ge ? (r_sq3_root[k] | (pas_pkg::VY_W'(1) << B))
                                  : r_sq3_root[k];
        end
    end

    // Result register; unreachable targets report zeros
    t_side fin;

    always_comb begin
        fin = r_sq3_side[S3N];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sq3_vld[S3N];
        end
        o_reachable <= fin.reach;
        if (!fin.reach) begin
            o_flight_time <= '0;
        end else if (|fin.t[TW-1:pas_pkg::TIME_W]) begin
            o_flight_time <= pas_pkg::TIME_MAX;
        end else begin
            o_flight_time <= fin.t[pas_pkg::TIME_W-1:0];
        end
        o_velocity_x <= fin.reach ? fin.vx : '0;
        o_velocity_y <= fin.reach ? r_sq3_root[S3N] : '0;
    end

    // Checks
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reachable |->
            o_flight_time == '0 && o_velocity_x == '0 && o_velocity_y == '0)
        else $error("unreachable result carries nonzero fields");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("result strobe missing after start");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without a matching start");

endmodule
